/* rtl/srr_pkg.sv */
// Shared widths, codes and the slot entry type of the selective-repeat receiver.
// No dependencies; imported by the receiver core.
`timescale 1ns / 1ps

package srr_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int SEQ_W    = 31;
    localparam int LEN_W    = 11;
    localparam int HANDLE_W = 16;
    localparam int SENDER_W = 48;
    localparam int KIND_W   = 2;
    localparam int BYTES_W  = 32;
    localparam int CFG_W    = 6;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 96;

    // Defaults
    localparam int DEFAULT_WINDOW_DEPTH = 32;
    localparam int LAN_WINDOW_LEN       = 4;

    // Packet types
    localparam logic [FUNC_W-1:0] FUNC_SETUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIN   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUSY    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd3;

    // One stored packet of the reorder window
    typedef struct packed {
        logic                fin;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
    } t_slot_entry;

endpackage

/* rtl/selective_repeat_receiver_core.sv */
// Selective-repeat receiver core: window control, reorder slot memory and result register.
// Depends on srr_pkg.
`timescale 1ns / 1ps

// Channel    | Dir | Handshake                      | Payload
// -----------+-----+--------------------------------+-------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready  | tuser func; tdata seq, len, handle, sender
// m_axis     | out | m_axis_tvalid / m_axis_tready  | tuser kind; tdata seq..bytes; tlast last
// cfg        | in  | i_cfg_valid / o_cfg_ready      | i_cfg_data window length
//
// One packet is worked on at a time. An accepted packet goes to the decide state; one with no
// result returns to idle, a setup, a duplicate or a late fin goes on to the emit state, and a
// stored data or fin packet goes through the check state, a deliver state per delivered packet
// behind a check state that starts the registered slot memory read, the nack state for each
// sequence between the new expected sequence and the packet, and the emit state. After reset,
// a window write or a sequence wrap, the next packet first passes the bit-serial remainder
// unit that finds the slot of the expected sequence. Reset is synchronous; it resets all
// control state and clears the slot valid bits at once. Each result waits in the output
// register while m_axis_tready is low, and the sequencer holds until that register is free.
module selective_repeat_receiver_core #(
    parameter int WINDOW_DEPTH = srr_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srr_pkg::CFG_W-1:0]       i_cfg_data,    // window length
    // Packet descriptor input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: seq[30:0], packet_len[41:31], buffer_handle[57:42],
    // sender_id[105:58], zero fill[111:106]
    input  logic [srr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [srr_pkg::FUNC_W-1:0]      s_axis_tuser,  // func
    // Result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: out_seq[30:0], out_len[41:31], out_handle[57:42],
    // out_fin[58], bytes_total[90:59], zero fill[95:91]
    output logic [srr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [srr_pkg::KIND_W-1:0]      m_axis_tuser,  // kind
    output logic                            m_axis_tlast   // last
);
    import srr_pkg::*;

    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = $clog2(SEQ_W);
    localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(WINDOW_DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_DELIV  = 3'd4;
    localparam logic [2:0] ST_NACK   = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    // Control state
    logic [2:0]              r_state,    n_state;
    logic [CFG_W-1:0]        r_window,   n_window;
    logic                    r_active,   n_active;
    logic [SEQ_W-1:0]        r_exp,      n_exp;
    logic [SENDER_W-1:0]     r_sender,   n_sender;
    logic [WINDOW_DEPTH-1:0] r_valid,    n_valid;
    logic [BYTES_W-1:0]      r_bytes,    n_bytes;
    logic [IW-1:0]           r_exp_slot, n_exp_slot;
    logic                    r_dirty,    n_dirty;
    logic [SEQ_W-1:0]        r_div_sh,   n_div_sh;
    logic [WW-1:0]           r_rem,      n_rem;
    logic [CW-1:0]           r_cnt,      n_cnt;
    logic [SEQ_W:0]          r_cur,      n_cur;
    logic [IW-1:0]           r_idx,      n_idx;
    logic                    r_stop,     n_stop;
    logic [KIND_W-1:0]       r_res_kind, n_res_kind;
    logic [SEQ_W-1:0]        r_res_seq,  n_res_seq;
    logic                    r_out_valid;

    // Latched packet and output payload
    logic [FUNC_W-1:0]       r_func;
    logic [SEQ_W-1:0]        r_seq;
    logic [LEN_W-1:0]        r_len;
    logic [HANDLE_W-1:0]     r_handle;
    logic [SENDER_W-1:0]     r_in_sender;
    logic [KIND_W-1:0]       r_out_kind;
    logic [SEQ_W-1:0]        r_out_seq;
    logic [LEN_W-1:0]        r_out_len;
    logic [HANDLE_W-1:0]     r_out_handle;
    logic                    r_out_fin;
    logic [BYTES_W-1:0]      r_out_bytes;
    logic                    r_out_last;

    // Slot memory
    t_slot_entry             r_slot_mem [WINDOW_DEPTH];
    t_slot_entry             r_rd_data;
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    t_slot_entry             mem_wdata;
    logic                    mem_re;

    // Result load
    logic                    emit;
    logic [KIND_W-1:0]       e_kind;
    logic [SEQ_W-1:0]        e_seq;
    logic [LEN_W-1:0]        e_len;
    logic [HANDLE_W-1:0]     e_handle;
    logic                    e_fin;
    logic [BYTES_W-1:0]      e_bytes;

    logic                    in_accept;
    logic                    out_free;
    logic [WW-1:0]           win;
    logic [IW-1:0]           idx_inc;
    logic [BYTES_W:0]        byte_sum;
    logic [BYTES_W-1:0]      byte_sat;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    // Effective window: zero acts as one, large values clamp to the depth
    always_comb begin
        if (r_window == '0) begin
            win = WW'(1);
        end else if (r_window > DEPTH_CFG) begin
            win = WW'(WINDOW_DEPTH);
        end else begin
            win = WW'(r_window);
        end
    end

    // Running slot index steps modulo the window
    assign idx_inc = (r_idx == IW'(win - WW'(1))) ? '0 : r_idx + IW'(1);

    // Saturating byte count for the packet being delivered
    assign byte_sum = {1'b0, r_bytes} + (BYTES_W + 1)'(r_rd_data.len);
    assign byte_sat = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];

    // Sequencer
    always_comb begin
        logic [WW:0]    rem_t;
        logic [SEQ_W:0] off;
        logic [WW:0]    slot_sum;
        logic [IW-1:0]  slot;

        n_state    = r_state;
        n_window   = r_window;
        n_active   = r_active;
        n_exp      = r_exp;
        n_sender   = r_sender;
        n_valid    = r_valid;
        n_bytes    = r_bytes;
        n_exp_slot = r_exp_slot;
        n_dirty    = r_dirty;
        n_div_sh   = r_div_sh;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_idx      = r_idx;
        n_stop     = r_stop;
        n_res_kind = r_res_kind;
        n_res_seq  = r_res_seq;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '{fin: (r_func == FUNC_FIN), handle: r_handle, len: r_len};
        mem_re    = 1'b0;

        emit     = 1'b0;
        e_kind   = KIND_ACK;
        e_seq    = '0;
        e_len    = '0;
        e_handle = '0;
        e_fin    = 1'b0;
        e_bytes  = r_bytes;

        // Slot of an in-window packet from its distance to the expected sequence
        off      = {1'b0, r_seq} - {1'b0, r_exp};
        slot_sum = (WW + 1)'(r_exp_slot) + (WW + 1)'(off[WW-1:0]);
        if (slot_sum >= {1'b0, win}) begin
            slot_sum = slot_sum - {1'b0, win};
        end
        slot = slot_sum[IW-1:0];

        rem_t = {r_rem, r_div_sh[SEQ_W-1]};

        // A window write forces the expected slot to be found again
        if (i_cfg_valid) begin
            n_window = i_cfg_data;
            n_dirty  = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_div_sh = r_exp;
                    n_rem    = '0;
                    n_cnt    = '0;
                    n_state  = r_dirty ? ST_MOD : ST_DECIDE;
                end
            end

            // Restoring remainder of the expected sequence by the window, one bit a cycle
            ST_MOD: begin
                if (rem_t >= {1'b0, win}) begin
                    rem_t = rem_t - {1'b0, win};
                end
                n_rem    = rem_t[WW-1:0];
                n_div_sh = r_div_sh << 1;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == CW'(SEQ_W - 1)) begin
                    n_exp_slot = rem_t[IW-1:0];
                    n_dirty    = 1'b0;
                    n_state    = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_state = ST_IDLE;
                case (r_func)
                    FUNC_SETUP: begin
                        n_res_seq = '0;
                        n_state   = ST_EMIT;
                        if (!r_active) begin
                            n_active   = 1'b1;
                            n_exp      = SEQ_W'(1);
                            n_sender   = r_in_sender;
                            n_bytes    = '0;
                            n_valid    = '0;
                            n_exp_slot = (win == WW'(1)) ? '0 : IW'(1);
                            n_res_kind = KIND_ACK;
                        end else if (r_in_sender == r_sender) begin
                            n_res_kind = KIND_ACK;
                        end else begin
                            n_res_kind = KIND_BUSY;
                        end
                    end
                    FUNC_DATA, FUNC_FIN: begin
                        if (!r_active) begin
                            // Late fin of the finished transfer is acked again
                            if (r_func == FUNC_FIN && r_seq == r_exp - SEQ_W'(1)) begin
                                n_res_kind = KIND_ACK;
                                n_res_seq  = r_seq;
                                n_state    = ST_EMIT;
                            end
                        end else if ({1'b0, r_seq} >= {1'b0, r_exp} + (SEQ_W + 1)'(win)) begin
                            n_state = ST_IDLE;
                        end else if (r_seq < r_exp) begin
                            // Duplicate: cumulative ack only
                            n_res_kind = KIND_ACK;
                            n_res_seq  = r_exp - SEQ_W'(1);
                            n_state    = ST_EMIT;
                        end else begin
                            if (!r_valid[slot]) begin
                                n_valid[slot] = 1'b1;
                                mem_we        = 1'b1;
                                mem_waddr     = slot;
                            end
                            n_cur   = {1'b0, r_exp};
                            n_idx   = r_exp_slot;
                            n_stop  = 1'b0;
                            n_state = ST_CHECK;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            // Read the next in-order slot, or close the delivery run
            ST_CHECK: begin
                if (!r_stop && r_valid[r_idx]) begin
                    mem_re  = 1'b1;
                    n_state = ST_DELIV;
                end else begin
                    n_exp = r_cur[SEQ_W-1:0];
                    if (r_cur[SEQ_W]) begin
                        n_dirty = 1'b1;
                    end else begin
                        n_exp_slot = r_idx;
                    end
                    n_res_kind = KIND_ACK;
                    n_res_seq  = r_cur[SEQ_W-1:0] - SEQ_W'(1);
                    n_state    = ST_NACK;
                end
            end

            ST_DELIV: begin
                if (out_free) begin
                    emit          = 1'b1;
                    e_kind        = KIND_DELIVER;
                    e_seq         = r_cur[SEQ_W-1:0];
                    e_len         = r_rd_data.len;
                    e_handle      = r_rd_data.handle;
                    e_fin         = r_rd_data.fin;
                    e_bytes       = byte_sat;
                    n_bytes       = byte_sat;
                    n_valid[r_idx] = 1'b0;
                    n_cur         = r_cur + (SEQ_W + 1)'(1);
                    n_idx         = idx_inc;
                    if (r_rd_data.fin) begin
                        n_active = 1'b0;
                        n_stop   = 1'b1;
                    end
                    n_state = ST_CHECK;
                end
            end

            // Nack each empty slot between the expected sequence and the packet
            ST_NACK: begin
                if (r_cur < {1'b0, r_seq}) begin
                    if (r_valid[r_idx]) begin
                        n_cur = r_cur + (SEQ_W + 1)'(1);
                        n_idx = idx_inc;
                    end else if (out_free) begin
                        emit   = 1'b1;
                        e_kind = KIND_NACK;
                        e_seq  = r_cur[SEQ_W-1:0];
                        n_cur  = r_cur + (SEQ_W + 1)'(1);
                        n_idx  = idx_inc;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end

            // Final ack or busy reply
            ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = r_res_kind;
                    e_seq   = r_res_seq;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= CFG_W'(LAN_WINDOW_LEN);
            r_active    <= 1'b0;
            r_exp       <= SEQ_W'(1);
            r_sender    <= '0;
            r_valid     <= '0;
            r_bytes     <= '0;
            r_exp_slot  <= '0;
            r_dirty     <= 1'b1;
            r_div_sh    <= '0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_stop      <= 1'b0;
            r_res_kind  <= KIND_ACK;
            r_res_seq   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_active    <= n_active;
            r_exp       <= n_exp;
            r_sender    <= n_sender;
            r_valid     <= n_valid;
            r_bytes     <= n_bytes;
            r_exp_slot  <= n_exp_slot;
            r_dirty     <= n_dirty;
            r_div_sh    <= n_div_sh;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_cur       <= n_cur;
            r_idx       <= n_idx;
            r_stop      <= n_stop;
            r_res_kind  <= n_res_kind;
            r_res_seq   <= n_res_seq;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Packet capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func      <= s_axis_tuser;
            r_seq       <= s_axis_tdata[SEQ_W-1:0];
            r_len       <= s_axis_tdata[SEQ_W +: LEN_W];
            r_handle    <= s_axis_tdata[SEQ_W + LEN_W +: HANDLE_W];
            r_in_sender <= s_axis_tdata[SEQ_W + LEN_W + HANDLE_W +: SENDER_W];
        end
        if (emit) begin
            r_out_kind   <= e_kind;
            r_out_seq    <= e_seq;
            r_out_len    <= e_len;
            r_out_handle <= e_handle;
            r_out_fin    <= e_fin;
            r_out_bytes  <= e_bytes;
            r_out_last   <= (e_kind == KIND_ACK) || (e_kind == KIND_BUSY);
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_slot_mem[r_idx];
        end
    end

    // Ports
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - SEQ_W - LEN_W - HANDLE_W - 1 - BYTES_W)'(0),
        r_out_bytes, r_out_fin, r_out_handle, r_out_len, r_out_seq
    };

    // Checks
    a_one_packet_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready
    ) else $error("input accepted while a packet is still in work");

    a_deliver_slot_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELIV) |-> r_valid[r_idx]
    ) else $error("delivering from an empty slot");

    a_last_on_final_reply: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast ==
            ((m_axis_tuser == KIND_ACK) || (m_axis_tuser == KIND_BUSY)))
    ) else $error("last flag does not match the final reply");

endmodule

/* tb/selective_repeat_receiver_core_test.sv */
// Self-checking testbench for the selective-repeat receiver core: directed and random packet
// streams with a behavioral receiver model checked reply by reply.
// Depends on srr_pkg and selective_repeat_receiver_core.
`timescale 1ns / 1ps

module selective_repeat_receiver_core_test;
    import srr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
    localparam int MAX_WINDOW     = DEFAULT_WINDOW_DEPTH;
    localparam int SLOT_W         = $clog2(MAX_WINDOW);
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 60;

    // One reply as it should leave the master side.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
        logic                fin;
        logic [BYTES_W-1:0]  bytes;
        logic                last;
    } t_reply;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Receiver model state.
    logic                  rx_active;
    logic [SEQ_W-1:0]      rx_next;
    logic [SENDER_W-1:0]   rx_sender;
    logic [MAX_WINDOW-1:0] rx_held;
    t_slot_entry           rx_slot [MAX_WINDOW];
    logic [BYTES_W-1:0]    rx_bytes;
    logic [CFG_W-1:0]      rx_window;

    t_reply              awaited_replies [$];
    logic [SENDER_W-1:0] sender_pool [3];
    int unsigned         mismatch_count = 0;
    bit                  tx_gaps_on     = 1'b1;
    bit                  rx_stalls_on   = 1'b1;
    bit                  hold_req       = 1'b0;

    selective_repeat_receiver_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return $urandom_range(20, 40);
        if (r < 35) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Window length in use: zero acts as one, anything past the depth as the depth.
    function automatic int unsigned window_len();
        if (rx_window == 0) return 1;
        if (rx_window > MAX_WINDOW) return MAX_WINDOW;
        return 32'(rx_window);
    endfunction

    // Slot of a sequence number in a window of the given length.
    function automatic logic [SLOT_W-1:0] slot_of(input int unsigned s, input int unsigned w);
        return SLOT_W'(s % w);
    endfunction

    function automatic void add_reply(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                                      input logic [LEN_W-1:0] len,
                                      input logic [HANDLE_W-1:0] handle, input logic fin);
        t_reply r;
        r.kind   = kind;
        r.seq    = seq;
        r.len    = len;
        r.handle = handle;
        r.fin    = fin;
        r.bytes  = rx_bytes;
        r.last   = 1'b0;
        awaited_replies.push_back(r);
    endfunction

    // Works out the replies to one accepted packet and advances the model.
    task automatic predict_replies(input logic [FUNC_W-1:0] func, input logic [SEQ_W-1:0] seq,
                                   input logic [LEN_W-1:0] len, input logic [HANDLE_W-1:0] handle,
                                   input logic [SENDER_W-1:0] sender);
        int unsigned       w;
        int unsigned       nxt;
        int unsigned       k;
        logic [SLOT_W-1:0] idx;
        int unsigned       n_before;
        t_slot_entry       e;
        logic [BYTES_W:0]  sum;
        t_reply            r;
        n_before = awaited_replies.size();
        w        = window_len();
        nxt      = {1'b0, rx_next};
        if (func == FUNC_SETUP) begin
            if (!rx_active) begin
                rx_active = 1'b1;
                rx_next   = SEQ_W'(1);
                rx_sender = sender;
                rx_bytes  = '0;
                rx_held   = '0;
                add_reply(KIND_ACK, '0, '0, '0, 1'b0);
            end else if (sender == rx_sender) begin
                add_reply(KIND_ACK, '0, '0, '0, 1'b0);
            end else begin
                add_reply(KIND_BUSY, '0, '0, '0, 1'b0);
            end
        end else if (func == FUNC_DATA || func == FUNC_FIN) begin
            if (!rx_active) begin
                // A repeat of the fin that closed the last transfer is acked again.
                if (func == FUNC_FIN && seq == SEQ_W'(nxt - 1))
                    add_reply(KIND_ACK, seq, '0, '0, 1'b0);
            end else if (seq < nxt + w) begin
                if (seq >= nxt) begin
                    idx = slot_of({1'b0, seq}, w);
                    if (!rx_held[idx]) begin
                        e.fin    = (func == FUNC_FIN);
                        e.handle = handle;
                        e.len    = len;
                        rx_held[idx] = 1'b1;
                        rx_slot[idx] = e;
                    end
                    // Deliver the in-order run; a fin closes the transfer.
                    while (rx_held[slot_of(nxt, w)]) begin
                        idx = slot_of(nxt, w);
                        e   = rx_slot[idx];
                        sum = {1'b0, rx_bytes} + (BYTES_W + 1)'(e.len);
                        rx_bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                        add_reply(KIND_DELIVER, SEQ_W'(nxt), e.len, e.handle, e.fin);
                        rx_held[idx] = 1'b0;
                        nxt++;
                        if (e.fin) begin
                            rx_active = 1'b0;
                            break;
                        end
                    end
                    for (k = nxt; k < seq; k++) begin
                        if (!rx_held[slot_of(k, w)])
                            add_reply(KIND_NACK, SEQ_W'(k), '0, '0, 1'b0);
                    end
                    rx_next = SEQ_W'(nxt);
                end
                add_reply(KIND_ACK, SEQ_W'(nxt - 1), '0, '0, 1'b0);
            end
        end
        if (awaited_replies.size() > n_before) begin
            r = awaited_replies.pop_back();
            r.last = 1'b1;
            awaited_replies.push_back(r);
        end
    endtask

    // Offers one packet, waits for the transaction and records its replies.
    task automatic send_packet(input logic [FUNC_W-1:0] func, input logic [SEQ_W-1:0] seq,
                               input logic [LEN_W-1:0] len, input logic [HANDLE_W-1:0] handle,
                               input logic [SENDER_W-1:0] sender);
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= IN_TDATA_W'({sender, handle, len, seq});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_replies(func, seq, len, handle, sender);
    endtask

    // Sender pauses until every reply is in and the core has had time to go idle.
    task automatic wait_replies_done();
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        wait_replies_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rx_window = value;
    endtask

    function automatic logic [SENDER_W-1:0] random_sender();
        if ($urandom_range(0, 4) == 0) return SENDER_W'({$urandom, $urandom});
        return sender_pool[$urandom_range(0, 2)];
    endfunction

    // Random packet shaped by the model state: mostly transfers that make progress.
    task automatic send_random_packet();
        int unsigned         pick;
        int unsigned         w;
        int unsigned         nxt;
        int unsigned         back;
        logic [FUNC_W-1:0]   func;
        logic [SEQ_W-1:0]    seq;
        logic [SENDER_W-1:0] sender;
        w      = window_len();
        nxt    = {1'b0, rx_next};
        pick   = $urandom_range(0, 99);
        func   = FUNC_DATA;
        seq    = SEQ_W'($urandom);
        sender = random_sender();
        if (!rx_active) begin
            // Mostly a new transfer; the rest are stray packets and a repeated fin.
            if (pick < 70) begin
                func = FUNC_SETUP;
            end else if (pick < 82) begin
                func = FUNC_FIN;
                seq  = SEQ_W'(nxt - 1);
            end else if (pick < 92) begin
                func = ($urandom_range(0, 1) != 0) ? FUNC_FIN : FUNC_DATA;
            end else begin
                func = FUNC_UNDEF;
            end
        end else if (pick < 68) begin
            // In the window, half of them close to the next expected sequence.
            if ($urandom_range(0, 1) != 0)
                seq = SEQ_W'(nxt + $urandom_range(0, (w > 3) ? 2 : w - 1));
            else
                seq = SEQ_W'(nxt + $urandom_range(0, w - 1));
            func = ($urandom_range(0, 12) == 0) ? FUNC_FIN : FUNC_DATA;
        end else if (pick < 78) begin
            back = (nxt - 1 < 2 * w) ? nxt - 1 : 2 * w;
            seq  = SEQ_W'(nxt - 1 - $urandom_range(0, back));
        end else if (pick < 86) begin
            // Past the window: just past it, or anywhere in the sequence space.
            if (pick < 82) seq = SEQ_W'(nxt + w + $urandom_range(0, 3));
        end else if (pick < 95) begin
            func = FUNC_SETUP;
            if ($urandom_range(0, 1) != 0) sender = rx_sender;
        end else begin
            func = FUNC_UNDEF;
        end
        send_packet(func, seq, LEN_W'($urandom), HANDLE_W'($urandom), sender);
    endtask

    // Packets that arrive with no transfer open.
    task automatic test_idle_packets();
        send_packet(FUNC_DATA, 31'd1, 11'h7FF, 16'hFFFF, sender_pool[0]);
        send_packet(FUNC_FIN, 31'd0, 11'd0, 16'd0, sender_pool[0]);
        send_packet(FUNC_FIN, 31'd7, 11'd5, 16'd9, sender_pool[0]);
        send_packet(FUNC_UNDEF, 31'd0, 11'd0, 16'd0, sender_pool[0]);
    endtask

    // Setup handling, reordering, duplicates, drops and the closing fin.
    task automatic test_setup_and_ordering();
        send_packet(FUNC_SETUP, 31'd0, 11'd0, 16'd0, {SENDER_W{1'b1}});
        send_packet(FUNC_SETUP, 31'd0, 11'd0, 16'd0, {SENDER_W{1'b1}});
        send_packet(FUNC_SETUP, 31'd0, 11'd0, 16'd0, {SENDER_W{1'b0}});
        send_packet(FUNC_DATA, 31'd1, 11'h7FF, 16'hFFFF, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'd3, 11'd0, 16'd0, {SENDER_W{1'b1}});
        // Same slot again: not stored a second time.
        send_packet(FUNC_DATA, 31'd3, 11'd100, 16'h1234, {SENDER_W{1'b1}});
        // Data from another sender is not filtered.
        send_packet(FUNC_DATA, 31'd2, 11'd17, 16'h00AA, {SENDER_W{1'b0}});
        send_packet(FUNC_DATA, 31'd1, 11'd3, 16'h0001, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'd8, 11'd3, 16'h0002, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'h7FFF_FFFF, 11'd3, 16'h0003, {SENDER_W{1'b1}});
        send_packet(FUNC_FIN, 31'd7, 11'd40, 16'h0707, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'd6, 11'd60, 16'h0606, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'd4, 11'd80, 16'h0404, {SENDER_W{1'b1}});
        send_packet(FUNC_DATA, 31'd5, 11'd50, 16'h0505, {SENDER_W{1'b1}});
        send_packet(FUNC_FIN, 31'd7, 11'd0, 16'd0, {SENDER_W{1'b1}});
    endtask

    // Window register at zero and at its top value, including a full row of nacks.
    task automatic test_window_extremes();
        write_window(6'd0);
        send_packet(FUNC_SETUP, 31'd0, 11'd0, 16'd0, sender_pool[2]);
        send_packet(FUNC_DATA, 31'd2, 11'd1, 16'd2, sender_pool[2]);
        send_packet(FUNC_DATA, 31'd1, 11'd9, 16'd3, sender_pool[2]);
        send_packet(FUNC_FIN, 31'd2, 11'd4, 16'd5, sender_pool[2]);
        write_window(6'h3F);
        send_packet(FUNC_SETUP, 31'd0, 11'd0, 16'd0, sender_pool[2]);
        send_packet(FUNC_FIN, 31'd32, 11'd12, 16'hBEEF, sender_pool[2]);
        send_packet(FUNC_DATA, 31'd1, 11'd7, 16'hCAFE, sender_pool[2]);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering packets.
    task automatic test_output_backpressure();
        wait_replies_done();
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        repeat (PHASE_ITEMS) send_random_packet();
        tx_gaps_on = 1'b1;
        wait_replies_done();
    endtask

    task automatic test_random_transfers(input logic [CFG_W-1:0] window, input bit idle_on);
        write_window(window);
        tx_gaps_on   = idle_on;
        rx_stalls_on = idle_on;
        repeat (PHASE_ITEMS) send_random_packet();
        wait_replies_done();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [BYTES_W-1:0] want,
                               input logic [BYTES_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every reply transaction is compared with the oldest predicted reply.
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply expected none, actual kind %0h tdata %h", $time,
                         m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("kind", BYTES_W'(want.kind), BYTES_W'(m_axis_tuser));
                check_field("out_seq", BYTES_W'(want.seq), BYTES_W'(m_axis_tdata[30:0]));
                check_field("out_len", BYTES_W'(want.len), BYTES_W'(m_axis_tdata[41:31]));
                check_field("out_handle", BYTES_W'(want.handle),
                            BYTES_W'(m_axis_tdata[57:42]));
                check_field("out_fin", BYTES_W'(want.fin), BYTES_W'(m_axis_tdata[58]));
                check_field("bytes_total", want.bytes, m_axis_tdata[90:59]);
                check_field("last", BYTES_W'(want.last), BYTES_W'(m_axis_tlast));
            end
        end
    end

    // Reply sink: random stalls, plus one long counted hold-off on request.
    initial begin : reply_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Test sequence.
    initial begin : stimulus
        rx_active = 1'b0;
        rx_next   = SEQ_W'(1);
        rx_sender = '0;
        rx_held   = '0;
        rx_bytes  = '0;
        rx_window = CFG_W'(LAN_WINDOW_LEN);
        foreach (sender_pool[i]) sender_pool[i] = SENDER_W'({$urandom, $urandom});
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_packets();
        test_setup_and_ordering();
        test_window_extremes();
        test_output_backpressure();
        test_random_transfers(6'd1, 1'b1);
        test_random_transfers(6'd32, 1'b1);
        test_random_transfers(CFG_W'($urandom_range(2, 31)), 1'b1);
        test_random_transfers(6'h3F, 1'b1);
        test_random_transfers(6'd0, 1'b1);
        test_random_transfers(CFG_W'(LAN_WINDOW_LEN), 1'b0);

        wait_replies_done();
        if (mismatch_count == 0) begin
            $display("selective_repeat_receiver_core: match");
        end else begin
            $display("selective_repeat_receiver_core: mismatch");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin : watchdog
        #40_000_000;
        $display("selective_repeat_receiver_core: mismatch");
        $finish;
    end

endmodule
